### sv/msclr_pkg.sv
// Shared widths, register indexes and reset values for the masked-sum reduce unit.
package msclr_pkg;

	localparam int CIPHER_W    = 63;
	localparam int PLAIN_MOD_W = 33;
	localparam int PLAIN_W     = 32;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_DATA_W  = 63;

	localparam logic [CFG_IDX_W-1:0] REG_CIPHER_MOD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PLAIN_MOD  = 1'b1;

	localparam logic [CIPHER_W-1:0]    CIPHER_MOD_RST  = 63'd2305843009213693951;
	localparam logic [CIPHER_W-1:0]    CIPHER_HALF_RST = 63'd1152921504606846975;
	localparam logic [PLAIN_MOD_W-1:0] PLAIN_MOD_RST   = 33'd65537;
	localparam logic [PLAIN_MOD_W-1:0] PLAIN_MOD_LIMIT = 33'h1_0000_0000;

	// Remainder by q, add and reduce, centre lift, remainder by t, final fix-up.
	localparam int LATENCY = 2 * CIPHER_W + 3;

endpackage

### sv/masked_sum_center_lift_reduce_unit.sv
// Top level of the masked-sum unmasking unit with centre lift and plaintext reduction.
// Throughput: one transaction per cycle, set by the three 63-stage remainder pipelines.
// The receiver cannot stall, so the pipeline never holds and busy stays low in operation.
// Reset (arst_n low, asynchronous) clears every valid bit, restores both moduli to their
// reset values and holds busy high until the first clock edge after release.
module masked_sum_center_lift_reduce_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	output logic                               busy,
	input  logic [msclr_pkg::CIPHER_W-1:0]     cipher_word,
	input  logic [msclr_pkg::CIPHER_W-1:0]     mask_word,
	output logic                               done,
	output logic [msclr_pkg::PLAIN_W-1:0]      plain_value,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [msclr_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [msclr_pkg::CFG_DATA_W-1:0]   cfg_data
);

	import msclr_pkg::*;

	// Configuration registers. The half of q and the saturated t are kept alongside so
	// that no derived arithmetic sits in front of the pipeline stages.
	logic [CIPHER_W-1:0]    cipher_mod_q;
	logic [CIPHER_W-1:0]    cipher_half_q;
	logic [PLAIN_MOD_W-1:0] t_eff_q;
	logic                   busy_q;

	// Valid and sign lines that travel beside the remainder pipelines by q and by t.
	logic                   vq_s [CIPHER_W];
	logic                   vt_s [CIPHER_W];
	logic                   negt_s [CIPHER_W];

	// Remainders of both operands by q, and of the centred magnitude by t.
	logic [CIPHER_W-1:0]    ra;
	logic [CIPHER_W-1:0]    rb;
	logic [PLAIN_MOD_W-1:0] rt;

	// Modular sum, then centre lift.
	logic                   vld_s64;
	logic [CIPHER_W-1:0]    raw_s64;
	logic                   vld_s65;
	logic                   neg_s65;
	logic [CIPHER_W-1:0]    mag_s65;

	logic                   done_q;
	logic [PLAIN_W-1:0]     plain_value_q;

	logic                   accept;
	logic                   q_zero;
	logic [CIPHER_W:0]      sum;
	logic [PLAIN_MOD_W-1:0] cfg_t;

	assign accept    = start && !busy_q;
	assign busy      = busy_q;
	assign cfg_ready = !busy_q;
	assign done      = done_q;
	assign plain_value = plain_value_q;
	assign q_zero    = (cipher_mod_q == '0);

	// Values of t above 2^32 behave as 2^32, so every remainder fits the 32-bit result.
	assign cfg_t = (cfg_data[PLAIN_MOD_W-1:0] > PLAIN_MOD_LIMIT) ?
			PLAIN_MOD_LIMIT : cfg_data[PLAIN_MOD_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b1;
			cipher_mod_q  <= CIPHER_MOD_RST;
			cipher_half_q <= CIPHER_HALF_RST;
			t_eff_q       <= PLAIN_MOD_RST;
		end else begin
			busy_q <= 1'b0;
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CIPHER_MOD: begin
						cipher_mod_q  <= cfg_data[CIPHER_W-1:0];
						cipher_half_q <= {1'b0, cfg_data[CIPHER_W-1:1]};
					end
					REG_PLAIN_MOD: begin
						t_eff_q <= cfg_t;
					end
					default: begin
					end
				endcase
			end
		end
	end

	// Both operands are reduced by q in parallel; a zero q leaves them untouched, and the
	// sum stage below forces the result to zero in that case.
	msclr_rem #(.XW(CIPHER_W), .DW(CIPHER_W)) u_rem_a (
		.clk (clk),
		.x   (cipher_word),
		.d   (cipher_mod_q),
		.r   (ra)
	);

	msclr_rem #(.XW(CIPHER_W), .DW(CIPHER_W)) u_rem_b (
		.clk (clk),
		.x   (mask_word),
		.d   (cipher_mod_q),
		.r   (rb)
	);

	// Both remainders are below q, so one conditional subtraction brings the sum below q.
	assign sum = {1'b0, ra} + {1'b0, rb};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CIPHER_W; i++) begin
				vq_s[i]   <= 1'b0;
				vt_s[i]   <= 1'b0;
			end
			vld_s64 <= 1'b0;
			vld_s65 <= 1'b0;
			done_q  <= 1'b0;
		end else begin
			vq_s[0] <= accept;
			vt_s[0] <= vld_s65;
			for (int i = 1; i < CIPHER_W; i++) begin
				vq_s[i] <= vq_s[i-1];
				vt_s[i] <= vt_s[i-1];
			end
			vld_s64 <= vq_s[CIPHER_W-1];
			vld_s65 <= vld_s64;
			done_q  <= vt_s[CIPHER_W-1];
		end
	end

	// Payload stages carry no reset; the valid line above qualifies them.
	always_ff @(posedge clk) begin
		if (q_zero) begin
			raw_s64 <= '0;
		end else if (sum >= {1'b0, cipher_mod_q}) begin
			raw_s64 <= CIPHER_W'(sum - {1'b0, cipher_mod_q});
		end else begin
			raw_s64 <= sum[CIPHER_W-1:0];
		end

		// A sum above the integer half of q stands for the negative value sum - q; only its
		// magnitude goes on to the reduction by t, and the sign travels beside it.
		if (!q_zero && (raw_s64 > cipher_half_q)) begin
			neg_s65 <= 1'b1;
			mag_s65 <= cipher_mod_q - raw_s64;
		end else begin
			neg_s65 <= 1'b0;
			mag_s65 <= raw_s64;
		end

		negt_s[0] <= neg_s65;
		for (int i = 1; i < CIPHER_W; i++) begin
			negt_s[i] <= negt_s[i-1];
		end

		// A zero t gives zero. A negative value with a non-zero remainder folds to t minus
		// that remainder, which is below 2^32 because the remainder is at least one.
		if (t_eff_q == '0) begin
			plain_value_q <= '0;
		end else if (negt_s[CIPHER_W-1] && (rt != '0)) begin
			plain_value_q <= PLAIN_W'(t_eff_q - rt);
		end else begin
			plain_value_q <= rt[PLAIN_W-1:0];
		end
	end

	msclr_rem #(.XW(CIPHER_W), .DW(PLAIN_MOD_W)) u_rem_t (
		.clk (clk),
		.x   (mag_s65),
		.d   (t_eff_q),
		.r   (rt)
	);

`ifndef ASSERT_OFF
	// Every accepted transaction yields its result exactly the pipeline depth later.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> ##LATENCY done_q)
		else $error("result strobe missing at the pipeline depth after acceptance");

	// A result strobe is only ever issued from a valid item leaving the reduction by t.
	a_done_src: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(vt_s[CIPHER_W-1]))
		else $error("result strobe without a valid item in the final stage");

	// With a zero plaintext modulus the result is forced to zero.
	a_t_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ($past(t_eff_q) == '0) |-> (plain_value_q == '0))
		else $error("non-zero result with a zero plaintext modulus");

	// A non-negative centred value passes its remainder through unchanged.
	a_pos_pass: assert property (@(posedge clk) disable iff (!arst_n)
		done_q && ($past(t_eff_q) != '0) && !$past(negt_s[CIPHER_W-1])
			|-> (plain_value_q == $past(rt[PLAIN_W-1:0])))
		else $error("remainder of a non-negative value altered in the final stage");
`endif

endmodule

### sv/msclr_rem.sv
// Pipelined restoring remainder: one dividend bit per register stage.
module msclr_rem #(
	parameter int XW = 63,
	parameter int DW = 63
) (
	input  logic          clk,
	input  logic [XW-1:0] x,
	input  logic [DW-1:0] d,
	output logic [DW-1:0] r
);

	logic [DW-1:0] part_s [XW];
	logic [XW-1:0] dvd_s  [XW-1];

	for (genvar k = 0; k < XW; k++) begin : g_step
		logic [XW-1:0] dvd_in;
		logic [DW-1:0] part_in;
		logic [DW:0]   trial;

		if (k == 0) begin : g_first
			assign dvd_in  = x;
			assign part_in = '0;
		end else begin : g_next
			assign dvd_in  = dvd_s[k-1];
			assign part_in = part_s[k-1];
		end

		// The partial remainder stays below d, so the shifted trial fits DW+1 bits.
		assign trial = {part_in, dvd_in[XW-1-k]};

		always_ff @(posedge clk) begin
			if (trial >= {1'b0, d}) begin
				part_s[k] <= DW'(trial - {1'b0, d});
			end else begin
				part_s[k] <= trial[DW-1:0];
			end
		end

		if (k < XW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				dvd_s[k] <= dvd_in;
			end
		end
	end

	assign r = part_s[XW-1];

endmodule
